/* src/lfu_pkg.sv */
// shared constants for the lfu cache table
package lfu_pkg;
  localparam int unsigned EntriesDef = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW = 5;
  // cells per registered segment of the victim chain
  localparam int unsigned ChainSeg = 4;
  localparam logic FuncGet = 1'b0;
  localparam logic FuncSet = 1'b1;
  localparam logic [DataW-1:0] MissData = '1;
endpackage

/* src/lfu_cell.sv */
// one slot of the table: key, data, use count, recency rank, and its link in the victim chain
module lfu_cell #(
  parameter int unsigned RankW  = 4,
  parameter int unsigned CountW = 16,
  parameter bit          RegOut = 1'b0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [lfu_pkg::KeyW-1:0] key_i,
  input  logic [lfu_pkg::DataW-1:0] value_i,
  input  logic                     touch_i,
  input  logic                     wdata_i,
  input  logic                     fill_i,
  input  logic                     drop_i,
  input  logic                     shift_up_i,
  input  logic                     shift_dn_i,
  input  logic [RankW-1:0]         ref_rank_i,
  input  logic                     age_all_i,
  input  logic                     chain_valid_i,
  input  logic [CountW-1:0]        chain_count_i,
  input  logic [RankW-1:0]         chain_rank_i,
  output logic                     chain_valid_o,
  output logic [CountW-1:0]        chain_count_o,
  output logic [RankW-1:0]         chain_rank_o,
  output logic                     chain_mine_o,
  output logic                     valid_o,
  output logic                     match_o,
  output logic [lfu_pkg::DataW-1:0] data_o,
  output logic [RankW-1:0]         rank_o
);
  logic                      valid_q;
  logic [lfu_pkg::KeyW-1:0]  key_q;
  logic [lfu_pkg::DataW-1:0] data_q;
  logic [CountW-1:0]         count_q;
  logic [RankW-1:0]          rank_q;
  logic                      better;
  logic                      chain_valid_d;
  logic [CountW-1:0]         chain_count_d;
  logic [RankW-1:0]          chain_rank_d;

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == key_i);
  assign data_o  = data_q;
  assign rank_o  = rank_q;

  // strictly better victim than the best seen so far in lower slots
  assign better = valid_q && (!chain_valid_i || count_q < chain_count_i ||
                  (count_q == chain_count_i && rank_q > chain_rank_i));
  assign chain_mine_o  = better;
  assign chain_valid_d = chain_valid_i || valid_q;
  assign chain_count_d = better ? count_q : chain_count_i;
  assign chain_rank_d  = better ? rank_q : chain_rank_i;

  // a registered link cuts the chain into short segments
  if (RegOut) begin : g_link_reg
    logic              chain_valid_q;
    logic [CountW-1:0] chain_count_q;
    logic [RankW-1:0]  chain_rank_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        chain_valid_q <= 1'b0;
        chain_count_q <= '0;
        chain_rank_q  <= '0;
      end else begin
        chain_valid_q <= chain_valid_d;
        chain_count_q <= chain_count_d;
        chain_rank_q  <= chain_rank_d;
      end
    end

    assign chain_valid_o = chain_valid_q;
    assign chain_count_o = chain_count_q;
    assign chain_rank_o  = chain_rank_q;
  end else begin : g_link_comb
    assign chain_valid_o = chain_valid_d;
    assign chain_count_o = chain_count_d;
    assign chain_rank_o  = chain_rank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
      rank_q  <= '0;
    end else if (fill_i) begin
      valid_q <= 1'b1;
      count_q <= CountW'(1);
      rank_q  <= '0;
    end else if (drop_i) begin
      valid_q <= 1'b0;
    end else if (touch_i) begin
      rank_q <= '0;
      if (count_q != '1) count_q <= count_q + CountW'(1);
    end else if (valid_q) begin
      if (shift_up_i && rank_q < ref_rank_i) rank_q <= rank_q + RankW'(1);
      else if (shift_dn_i && rank_q > ref_rank_i) rank_q <= rank_q - RankW'(1);
      else if (age_all_i) rank_q <= rank_q + RankW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i) key_q <= key_i;
    if (fill_i || wdata_i) data_q <= value_i;
  end
endmodule

/* src/lfu_cache_table.sv */
// top level of the lfu cache table with lru tie break
// channel | dir | tdata fields (low bit up)   | tuser
// s_axis  | in  | key[31:0], value[63:32]      | func
// m_axis  | out | read_data[31:0]              | hit
// cfg     | in  | capacity[4:0]                | -
// a get or a set hit passes accept, lookup, result before the next acceptance
// a set miss into a free slot passes accept, lookup, insert; an evicting set adds evict before insert
// the victim chain is registered every ChainSeg cells; a drop waits until the chain has
// settled, that is until every segment has seen the last table write
// reset clears all slots; capacity resets to 16
// the result waits in an output register; the next item enters once it is taken
module lfu_cache_table #(
  parameter int unsigned ENTRIES    = lfu_pkg::EntriesDef,
  parameter int unsigned COUNT_BITS = lfu_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key, value
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // read_data
  output logic        m_axis_tuser,  // hit
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i    // capacity
);
  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned IdxW  = RankW;
  localparam int unsigned NumW  = $clog2(ENTRIES + 1);
  localparam int unsigned SettleMin = (ENTRIES - 1) / lfu_pkg::ChainSeg;
  localparam int unsigned SetW = (SettleMin > 0) ? $clog2(SettleMin + 1) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;
  localparam logic [1:0] StEvict = 2'd2;
  localparam logic [1:0] StIns = 2'd3;

  logic [1:0] state_q, state_d;
  logic [4:0] cap_q;
  logic func_q;
  logic [31:0] key_q, val_q;
  logic out_v_q, hit_q;
  logic [31:0] rd_q;
  logic [IdxW-1:0] slot_q;
  logic [SetW-1:0] settle_q;
  logic settled;
  logic [RankW-1:0] ref_rank;

  logic [ENTRIES-1:0] valid, match, mine;
  logic [31:0] data_a [ENTRIES];
  logic [RankW-1:0] rank_a [ENTRIES];
  logic [ENTRIES:0] cv;
  logic [COUNT_BITS-1:0] cc [ENTRIES+1];
  logic [RankW-1:0] cr [ENTRIES+1];
  logic [ENTRIES-1:0] touch, wdat, fill, drop;
  logic shift_up, shift_dn, age_all;
  logic tbl_wr;

  assign cv[0] = 1'b0;
  assign cc[0] = '0;
  assign cr[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .RankW(RankW),
      .CountW(COUNT_BITS),
      .RegOut(((g % lfu_pkg::ChainSeg) == lfu_pkg::ChainSeg - 1) && (g != ENTRIES - 1))
    ) u_cell (
      .clk_i, .rst_ni,
      .key_i(key_q), .value_i(val_q),
      .touch_i(touch[g]), .wdata_i(wdat[g]), .fill_i(fill[g]), .drop_i(drop[g]),
      .shift_up_i(shift_up), .shift_dn_i(shift_dn), .ref_rank_i(ref_rank),
      .age_all_i(age_all),
      .chain_valid_i(cv[g]), .chain_count_i(cc[g]), .chain_rank_i(cr[g]),
      .chain_valid_o(cv[g+1]), .chain_count_o(cc[g+1]), .chain_rank_o(cr[g+1]),
      .chain_mine_o(mine[g]), .valid_o(valid[g]), .match_o(match[g]),
      .data_o(data_a[g]), .rank_o(rank_a[g])
    );
  end

  // lookup results
  logic f_found, f_free, need_evict;
  logic [IdxW-1:0] f_idx, f_freeidx, f_vic;
  logic [NumW-1:0] used;
  logic [NumW-1:0] cap_eff;
  always_comb begin
    f_found = 1'b0; f_free = 1'b0; f_idx = '0; f_freeidx = '0; f_vic = '0; used = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i]) used = used + NumW'(1);
      if (match[i] && !f_found) begin f_found = 1'b1; f_idx = IdxW'(i); end
      if (!valid[i] && !f_free) begin f_free = 1'b1; f_freeidx = IdxW'(i); end
      if (mine[i]) f_vic = IdxW'(i);
    end
    if (cap_q == '0) cap_eff = NumW'(1);
    else if (32'(cap_q) > ENTRIES) cap_eff = NumW'(ENTRIES);
    else cap_eff = NumW'(cap_q);
    need_evict = (used >= cap_eff) || !f_free;
  end

  // the chain tail is only trusted once every segment has seen the current table
  assign settled = (settle_q == SetW'(SettleMin));
  assign tbl_wr  = (|touch) || (|fill) || (|drop);
  assign ref_rank = (state_q == StEvict) ? rank_a[f_vic] : rank_a[f_idx];

  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = rd_q;
  assign m_axis_tuser  = hit_q;

  always_comb begin
    state_d = state_q;
    touch = '0; wdat = '0; fill = '0; drop = '0;
    shift_up = 1'b0; shift_dn = 1'b0; age_all = 1'b0;
    unique case (state_q)
      StIdle: if (s_axis_tvalid && s_axis_tready) state_d = StLook;
      StLook: begin
        if (f_found) begin
          // younger entries age by one, the hit entry becomes the most recent
          shift_up = 1'b1;
          touch[f_idx] = 1'b1;
          wdat[f_idx] = (func_q == lfu_pkg::FuncSet);
          state_d = StIdle;
        end else if (func_q == lfu_pkg::FuncGet) state_d = StIdle;
        else if (need_evict) state_d = StEvict;
        else state_d = StIns;
      end
      StEvict: begin
        if (settled) begin
          // entries older than the victim step their rank down by one
          drop[f_vic] = cv[ENTRIES];
          shift_dn = 1'b1;
          state_d = StIns;
        end
      end
      StIns: begin
        age_all = 1'b1;
        fill[slot_q] = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cap_q    <= 5'd16;
      out_v_q  <= 1'b0;
      settle_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (state_q == StLook) out_v_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (tbl_wr) settle_q <= '0;
      else if (!settled) settle_q <= settle_q + SetW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q  <= s_axis_tdata[31:0];
      val_q  <= s_axis_tdata[63:32];
      func_q <= s_axis_tuser;
    end
    if (state_q == StLook) begin
      hit_q <= f_found;
      rd_q  <= (f_found && func_q == lfu_pkg::FuncGet) ? data_a[f_idx] :
               (!f_found && func_q == lfu_pkg::FuncGet) ? lfu_pkg::MissData : '0;
      slot_q <= f_freeidx;
    end
    if (state_q == StEvict && settled) slot_q <= f_vic;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready);
  a_keys_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match));
  a_fill_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIns |-> !valid[slot_q]);
  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEvict && settled |-> cv[ENTRIES]);
endmodule
